// File: hdl/mli2c_pkg.sv
// shared types and constants for the multi-lane i2c master
`default_nettype none

package mli2c_pkg;

    localparam int LANES   = 9;
    localparam int LANE_W  = 4;
    localparam int BYTE_W  = 8;
    localparam int HOLD_W  = 8;
    localparam int OP_W    = 3;

    // command codes carried on the input stream
    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_START = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    // configuration register indexes
    localparam logic CFG_LANE_MASK  = 1'b0;
    localparam logic CFG_HOLD_TICKS = 1'b1;

    localparam logic [BYTE_W-1:0] LANE_MASK_RST  = 8'hFF;
    localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = 8'd4;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_ack;
        logic [LANES-1:0]  sda_sample;
    } t_item;

    typedef struct packed {
        logic             scl;
        logic [LANES-1:0] sda;
        logic             busy;
    } t_pins;

    typedef struct packed {
        t_pins             pins;
        logic              byte_ready;
        logic [LANE_W-1:0] lane;
        logic [BYTE_W-1:0] rx;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/multi_lane_i2c_master.sv
// top level of the multi-lane i2c master: stream ports, registers, result queue
`default_nettype none

// channel      | direction | transaction moves
// -------------+-----------+--------------------------------------------------
// s_t*         | in        | one command or tick: opcode in tuser, rest in tdata
// m_t*         | out       | one result: pin levels, status, optional lane byte
// i_cfg_*      | in        | one register write (0 lane_mask, 1 hold_ticks)
//
// one input transaction can be taken every cycle; the sequencer updates in that cycle
// and its result is offered on m_t* from the next cycle through a two-entry queue.
// input stalls while both queue entries wait. the tick that finishes a read
// emits nine lane results, one per cycle with a free queue entry, and input is held
// off until the last of them is queued.
// reset (synchronous, active low) idles the sequencer with scl high and all
// lanes released, restores lane_mask 255 and hold_ticks 4, empties the queue.
module multi_lane_i2c_master (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // tx_byte[7:0], send_ack[8], sda_sample[17:9], zero[23:18]
    input  wire  [2:0]  s_tuser,   // opcode[2:0]
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // scl_level[0], sda_release[9:1], busy_res[10],
                                   // lane_index[14:11], rx_byte[22:15], zero[23]
    output logic        m_tuser,   // byte_ready
    output logic        m_tlast,   // last_lane
    // register writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);

    localparam int QDEPTH = 2;

    logic [mli2c_pkg::BYTE_W-1:0] r_lane_mask;
    logic [mli2c_pkg::HOLD_W-1:0] r_hold_ticks;

    mli2c_pkg::t_item   item;
    mli2c_pkg::t_pins   pins_next;
    mli2c_pkg::t_pins   pins_now;
    logic               read_done;
    logic [mli2c_pkg::BYTE_W-1:0] lane_byte;
    logic               s_accept;
    logic               m_accept;

    // result queue
    mli2c_pkg::t_result r_queue [QDEPTH];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;
    logic               q_full;
    logic               push;
    mli2c_pkg::t_result push_res;
    mli2c_pkg::t_result head;

    // lane byte burst after a read
    logic               r_burst;
    logic [mli2c_pkg::LANE_W-1:0] r_burst_lane;
    logic               burst_push;
    logic               burst_last;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_mask  <= mli2c_pkg::LANE_MASK_RST;
            r_hold_ticks <= mli2c_pkg::HOLD_TICKS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mli2c_pkg::CFG_LANE_MASK:  r_lane_mask  <= i_cfg_data;
                mli2c_pkg::CFG_HOLD_TICKS: r_hold_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign q_full   = (r_count == 2'd2);
    assign s_tready = !r_burst && !q_full;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (r_count != 2'd0);
    assign m_accept = m_tvalid && m_tready;

    assign item = '{opcode:     s_tuser,
                    tx_byte:    s_tdata[7:0],
                    send_ack:   s_tdata[8],
                    sda_sample: s_tdata[17:9]};

    mli2c_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (s_accept),
        .i_item       (item),
        .i_lane_mask  (r_lane_mask),
        .i_hold_ticks (r_hold_ticks),
        .i_lane_sel   (r_burst_lane),
        .o_pins_next  (pins_next),
        .o_pins_now   (pins_now),
        .o_read_done  (read_done),
        .o_lane_byte  (lane_byte)
    );

    // burst entries carry the pin state left by the finishing tick
    assign burst_push = r_burst && !q_full;
    assign burst_last = (r_burst_lane == mli2c_pkg::LANE_W'(mli2c_pkg::LANES - 1));
    assign push       = (s_accept && !read_done) || burst_push;

    always_comb begin
        if (r_burst) begin
            push_res = '{pins: pins_now, byte_ready: 1'b1, lane: r_burst_lane,
                         rx: lane_byte, last: burst_last};
        end else begin
            push_res = '{pins: pins_next, byte_ready: 1'b0, lane: '0,
                         rx: '0, last: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst      <= 1'b0;
            r_burst_lane <= '0;
        end else if (s_accept && read_done) begin
            r_burst      <= 1'b1;
            r_burst_lane <= '0;
        end else if (burst_push) begin
            r_burst      <= !burst_last;
            r_burst_lane <= r_burst_lane + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= push_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push)     r_wr_ptr <= !r_wr_ptr;
            if (m_accept) r_rd_ptr <= !r_rd_ptr;
            if (push && !m_accept)      r_count <= r_count + 2'd1;
            else if (!push && m_accept) r_count <= r_count - 2'd1;
        end
    end

    assign head    = r_queue[r_rd_ptr];
    assign m_tdata = {1'b0, head.rx, head.lane, head.pins.busy, head.pins.sda, head.pins.scl};
    assign m_tuser = head.byte_ready;
    assign m_tlast = head.last;

endmodule

`default_nettype wire

// File: hdl/mli2c_seq.sv
// pin step sequencer: command state, hold counter, shifters and pin levels
`default_nettype none

module mli2c_seq (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_accept,
    input  mli2c_pkg::t_item             i_item,
    input  wire [mli2c_pkg::BYTE_W-1:0]  i_lane_mask,
    input  wire [mli2c_pkg::HOLD_W-1:0]  i_hold_ticks,
    input  wire [mli2c_pkg::LANE_W-1:0]  i_lane_sel,
    output mli2c_pkg::t_pins             o_pins_next,
    output mli2c_pkg::t_pins             o_pins_now,
    output logic                         o_read_done,
    output logic [mli2c_pkg::BYTE_W-1:0] o_lane_byte
);

    typedef enum logic [2:0] {
        KIND_IDLE  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_WRITE = 3'd3,
        KIND_READ  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ACT_SCL0, ACT_SCL1, ACT_SDA0, ACT_SDA1, ACT_SDA_BIT, ACT_WAIT, ACT_END
    } t_act;

    localparam int PHASE_W = 5;
    localparam int SUB_W   = 2;

    t_kind                      r_kind, n_kind;
    logic [PHASE_W-1:0]         r_phase, n_phase;
    logic [SUB_W-1:0]           r_sub, n_sub;
    logic [mli2c_pkg::HOLD_W-1:0] r_hold, n_hold;
    logic [mli2c_pkg::BYTE_W-1:0] r_tx, n_tx;
    logic [mli2c_pkg::BYTE_W-1:0] r_lane [mli2c_pkg::LANES];
    logic [mli2c_pkg::BYTE_W-1:0] n_lane [mli2c_pkg::LANES];
    logic                       r_scl, n_scl;
    logic [mli2c_pkg::LANES-1:0] r_sda, n_sda;
    logic                       r_ack, n_ack;

    logic [mli2c_pkg::HOLD_W-1:0] hold_load;
    logic [mli2c_pkg::HOLD_W-1:0] hold_dec;
    logic [PHASE_W-1:0]         phase_nxt;
    logic [SUB_W-1:0]           sub_nxt;
    logic [mli2c_pkg::LANES-1:0] drive_en;
    t_act                       act;
    logic                       do_apply;
    logic                       sda_level;

    // pin action of step p of a command
    function automatic t_act step_action(t_kind kind, logic [PHASE_W-1:0] p,
                                         logic [SUB_W-1:0] sub);
        t_act a;
        a = ACT_END;
        unique case (kind)
            KIND_START: begin
                unique case (p)
                    5'd0:    a = ACT_SCL1;
                    5'd1:    a = ACT_SDA1;
                    5'd2:    a = ACT_SCL1;
                    5'd3:    a = ACT_SDA0;
                    5'd4:    a = ACT_SCL0;
                    5'd5:    a = ACT_SDA1;
                    default: a = ACT_END;
                endcase
            end
            KIND_STOP: begin
                unique case (p)
                    5'd0:    a = ACT_SCL0;
                    5'd1:    a = ACT_SDA0;
                    5'd2:    a = ACT_SCL1;
                    5'd3:    a = ACT_SDA0;
                    5'd4:    a = ACT_SCL1;
                    5'd5:    a = ACT_SDA1;
                    default: a = ACT_END;
                endcase
            end
            KIND_WRITE: begin
                if (p < 5'd24) begin
                    if (sub == 2'd0)      a = ACT_SCL0;
                    else if (sub == 2'd1) a = ACT_SDA_BIT;
                    else                  a = ACT_SCL1;
                end else begin
                    unique case (p)
                        5'd24:   a = ACT_SCL0;
                        5'd25:   a = ACT_SDA1;
                        5'd26:   a = ACT_SCL1;
                        5'd27:   a = ACT_SCL0;
                        5'd28:   a = ACT_WAIT;
                        default: a = ACT_END;
                    endcase
                end
            end
            KIND_READ: begin
                if (p == 5'd0)       a = ACT_SCL0;
                else if (p == 5'd1)  a = ACT_SDA1;
                else if (p <= 5'd17) a = p[0] ? ACT_SCL0 : ACT_SCL1;
                else begin
                    unique case (p)
                        5'd18:   a = ACT_SDA0;
                        5'd19:   a = ACT_SCL1;
                        5'd20:   a = ACT_SCL0;
                        5'd21:   a = ACT_WAIT;
                        default: a = ACT_END;
                    endcase
                end
            end
            default: a = ACT_END;
        endcase
        return a;
    endfunction

    assign hold_load = (i_hold_ticks == '0) ? {{(mli2c_pkg::HOLD_W-1){1'b0}}, 1'b1}
                                            : i_hold_ticks;
    assign hold_dec  = (r_hold != '0) ? r_hold - 1'b1 : r_hold;
    assign sub_nxt   = (r_sub == 2'd2) ? 2'd0 : r_sub + 2'd1;
    // lanes above the mask width are always driven
    assign drive_en  = {{(mli2c_pkg::LANES-mli2c_pkg::BYTE_W){1'b1}}, i_lane_mask};

    always_comb begin
        n_kind      = r_kind;
        n_phase     = r_phase;
        n_sub       = r_sub;
        n_hold      = r_hold;
        n_tx        = r_tx;
        n_lane      = r_lane;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_ack       = r_ack;
        o_read_done = 1'b0;
        act         = ACT_WAIT;
        do_apply    = 1'b0;
        phase_nxt   = r_phase + 1'b1;

        if (i_accept) begin
            if (i_item.opcode == mli2c_pkg::OP_TICK) begin
                if (r_kind != KIND_IDLE) begin
                    if (hold_dec != '0) begin
                        n_hold = hold_dec;
                    end else begin
                        if (r_kind == KIND_WRITE && r_phase < 5'd24 && r_sub == 2'd2) begin
                            n_tx = {r_tx[mli2c_pkg::BYTE_W-2:0], 1'b0};
                        end
                        // sample every lane at the end of a clock-high step
                        if (r_kind == KIND_READ && r_phase >= 5'd2 && r_phase <= 5'd17 &&
                            !r_phase[0]) begin
                            for (int k = 0; k < mli2c_pkg::LANES; k++) begin
                                n_lane[k] = {r_lane[k][mli2c_pkg::BYTE_W-2:0],
                                             i_item.sda_sample[k]};
                            end
                        end
                        // ack step skipped when no ack was asked for
                        if (r_kind == KIND_READ && phase_nxt == 5'd18 && !r_ack) begin
                            phase_nxt = 5'd19;
                        end
                        act = step_action(r_kind, phase_nxt, sub_nxt);
                        if (act != ACT_END) begin
                            n_phase  = phase_nxt;
                            n_sub    = sub_nxt;
                            n_hold   = hold_load;
                            do_apply = 1'b1;
                        end else begin
                            n_kind      = KIND_IDLE;
                            n_phase     = '0;
                            n_hold      = '0;
                            o_read_done = (r_kind == KIND_READ);
                        end
                    end
                end
            end else if (r_kind == KIND_IDLE && i_item.opcode <= mli2c_pkg::OP_READ) begin
                n_kind  = t_kind'(i_item.opcode);
                n_phase = '0;
                n_sub   = '0;
                n_hold  = hold_load;
                if (i_item.opcode == mli2c_pkg::OP_WRITE) begin
                    n_tx = i_item.tx_byte;
                end
                if (i_item.opcode == mli2c_pkg::OP_READ) begin
                    n_ack = i_item.send_ack;
                    for (int k = 0; k < mli2c_pkg::LANES; k++) begin
                        n_lane[k] = '0;
                    end
                end
                act      = step_action(t_kind'(i_item.opcode), '0, '0);
                do_apply = 1'b1;
            end
        end

        sda_level = (act == ACT_SDA1) || (act == ACT_SDA_BIT && n_tx[mli2c_pkg::BYTE_W-1]);
        if (do_apply) begin
            case (act)
                ACT_SCL0: n_scl = 1'b0;
                ACT_SCL1: n_scl = 1'b1;
                ACT_SDA0, ACT_SDA1, ACT_SDA_BIT: begin
                    for (int k = 0; k < mli2c_pkg::LANES; k++) begin
                        if (drive_en[k]) n_sda[k] = sda_level;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_IDLE;
            r_phase <= '0;
            r_sub   <= '0;
            r_hold  <= '0;
            r_tx    <= '0;
            r_scl   <= 1'b1;
            r_sda   <= '1;
            r_ack   <= 1'b0;
            for (int k = 0; k < mli2c_pkg::LANES; k++) begin
                r_lane[k] <= '0;
            end
        end else begin
            r_kind  <= n_kind;
            r_phase <= n_phase;
            r_sub   <= n_sub;
            r_hold  <= n_hold;
            r_tx    <= n_tx;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_ack   <= n_ack;
            r_lane  <= n_lane;
        end
    end

    assign o_pins_next = '{scl: n_scl, sda: n_sda, busy: (n_kind != KIND_IDLE)};
    assign o_pins_now  = '{scl: r_scl, sda: r_sda, busy: (r_kind != KIND_IDLE)};
    assign o_lane_byte = r_lane[i_lane_sel];

endmodule

`default_nettype wire
